/* rtl/core/dfa_pkg.sv */
package dfa_pkg;

  localparam int NUM_STATES  = 256;
  localparam int NUM_SYMBOLS = 128;

  localparam int STATE_W = $clog2(NUM_STATES);
  localparam int SYM_W   = $clog2(NUM_SYMBOLS);
  localparam int ADDR_W  = STATE_W + SYM_W;
  localparam int TABLE_DEPTH = NUM_STATES * NUM_SYMBOLS;

  // Fixed field widths of the request and result ports
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 8;
  localparam int CHAR_W  = 7;
  localparam int TGT_W   = 9;
  localparam int KIND_W  = 8;
  localparam int LEN_W   = 16;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Request codes
  localparam logic [REQ_W-1:0] OP_TRANS  = 2'd0;
  localparam logic [REQ_W-1:0] OP_ACCEPT = 2'd1;
  localparam logic [REQ_W-1:0] OP_SCAN   = 2'd2;
  localparam logic [REQ_W-1:0] OP_NONE   = 2'd3;

  // Request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Result buffer
  localparam int OUT_DEPTH = 2;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [REQ_W-1:0]  op;
    logic [IDX_W-1:0]  state_index;
    logic [CHAR_W-1:0] symbol;
    logic [TGT_W-1:0]  target_state;
    logic              accepting;
    logic [KIND_W-1:0] token_code;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              failed;
    logic [LEN_W-1:0]  length;
  } result_t;

endpackage

/* rtl/core/dfa_front.sv */
module dfa_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [dfa_pkg::REQ_W-1:0]           req_type,
  input  logic [dfa_pkg::IDX_W-1:0]           state_index,
  input  logic [dfa_pkg::CHAR_W-1:0]          symbol,
  input  logic signed [dfa_pkg::TGT_W-1:0]    target_state,
  input  logic                                accepting,
  input  logic [dfa_pkg::KIND_W-1:0]          token_code,
  output logic                                item_valid,
  output dfa_pkg::item_t                      item,
  input  logic                                item_pop
);

  dfa_pkg::item_t q [dfa_pkg::QDEPTH];
  logic [dfa_pkg::QPTR_W-1:0] wr_ptr;
  logic [dfa_pkg::QPTR_W-1:0] rd_ptr;
  logic [dfa_pkg::QCNT_W-1:0] count;
  logic [dfa_pkg::QCNT_W-1:0] count_next;
  logic                       push;
  dfa_pkg::item_t             in_item;

  assign req_stall = (count == dfa_pkg::QCNT_W'(dfa_pkg::QDEPTH));
  // Drop the unused request code at the door
  assign push = req_valid && !req_stall && (req_type != dfa_pkg::OP_NONE);

  always_comb begin
    in_item.op           = req_type;
    in_item.state_index  = state_index;
    in_item.symbol       = symbol;
    in_item.target_state = target_state;
    in_item.accepting    = accepting;
    in_item.token_code   = token_code;
  end

  assign count_next = count + dfa_pkg::QCNT_W'(push) - dfa_pkg::QCNT_W'(item_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (item_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= in_item;
  end

  assign item_valid = (count != '0);
  assign item       = q[rd_ptr];

endmodule

/* rtl/core/dfa_back.sv */
module dfa_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  dfa_pkg::item_t                 item,
  output logic                           item_pop,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [dfa_pkg::KIND_W-1:0]     matched_kind,
  output logic                           failed,
  output logic [dfa_pkg::LEN_W-1:0]      word_length
);

  localparam logic [dfa_pkg::SYM_W-1:0] CH_NUL   = dfa_pkg::SYM_W'(0);
  localparam logic [dfa_pkg::SYM_W-1:0] CH_TAB   = dfa_pkg::SYM_W'(9);
  localparam logic [dfa_pkg::SYM_W-1:0] CH_LF    = dfa_pkg::SYM_W'(10);
  localparam logic [dfa_pkg::SYM_W-1:0] CH_SPACE = dfa_pkg::SYM_W'(32);

  // Tables
  logic [dfa_pkg::TGT_W-1:0]  tstore [dfa_pkg::TABLE_DEPTH];
  logic [dfa_pkg::KIND_W-1:0] kstore [dfa_pkg::NUM_STATES];
  logic [dfa_pkg::NUM_STATES-1:0] flags;

  // Lookup stage
  logic                       s1_valid;
  logic [dfa_pkg::TGT_W-1:0]  rdata;
  logic                       flag_q;
  logic [dfa_pkg::KIND_W-1:0] kind_q;
  logic [dfa_pkg::SYM_W-1:0]  sym_q;

  // Scan position
  logic [dfa_pkg::STATE_W-1:0] cur_state;
  logic [dfa_pkg::STATE_W-1:0] cur_state_next;
  logic [dfa_pkg::LEN_W-1:0]   pos;
  logic [dfa_pkg::LEN_W-1:0]   pos_next;

  logic                        res_push;
  dfa_pkg::result_t            res_new;

  // Result buffer
  dfa_pkg::result_t            obuf [dfa_pkg::OUT_DEPTH];
  logic [dfa_pkg::OPTR_W-1:0]  owr_ptr;
  logic [dfa_pkg::OPTR_W-1:0]  ord_ptr;
  logic [dfa_pkg::OCNT_W-1:0]  occ;
  logic [dfa_pkg::OCNT_W:0]    load;
  logic                        drain;
  logic                        credit_ok;

  logic                        scan_issue;
  logic                        trans_wr;
  logic                        accept_wr;
  logic [dfa_pkg::STATE_W-1:0] wr_state;
  logic [dfa_pkg::SYM_W-1:0]   item_sym;
  logic                        blank;
  logic                        has_edge;

  assign wr_state = item.state_index[dfa_pkg::STATE_W-1:0];
  assign item_sym = item.symbol[dfa_pkg::SYM_W-1:0];

  // Reserve a result slot for every scan in flight
  assign drain     = res_valid && !res_stall;
  assign load      = (dfa_pkg::OCNT_W+1)'(occ) + (dfa_pkg::OCNT_W+1)'(s1_valid);
  assign credit_ok = load < ((dfa_pkg::OCNT_W+1)'(dfa_pkg::OUT_DEPTH)
                             + (dfa_pkg::OCNT_W+1)'(drain));

  assign item_pop   = item_valid && ((item.op != dfa_pkg::OP_SCAN) || credit_ok);
  assign scan_issue = item_pop && (item.op == dfa_pkg::OP_SCAN);
  assign trans_wr   = item_pop && (item.op == dfa_pkg::OP_TRANS);
  assign accept_wr  = item_pop && (item.op == dfa_pkg::OP_ACCEPT);

  // Resolve the looked-up edge; its state addresses the next scan directly
  assign has_edge = !rdata[dfa_pkg::TGT_W-1];
  assign blank    = (sym_q == CH_SPACE) || (sym_q == CH_TAB) ||
                    (sym_q == CH_LF) || (sym_q == CH_NUL);

  always_comb begin
    cur_state_next = cur_state;
    pos_next       = pos;
    res_push       = 1'b0;
    res_new.kind   = '0;
    res_new.failed = 1'b1;
    res_new.length = pos;
    if (s1_valid) begin
      if (has_edge) begin
        cur_state_next = rdata[dfa_pkg::STATE_W-1:0];
        pos_next       = (pos == dfa_pkg::LEN_MAX) ? pos : pos + dfa_pkg::LEN_W'(1);
      end else begin
        cur_state_next = '0;
        pos_next       = '0;
        res_push       = 1'b1;
        if (pos == '0) begin
          res_new.length = dfa_pkg::LEN_W'(1);
        end else if (flag_q && blank) begin
          res_new.kind   = kind_q;
          res_new.failed = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      cur_state <= '0;
      pos       <= '0;
      flags     <= '0;
    end else begin
      s1_valid  <= scan_issue;
      cur_state <= cur_state_next;
      pos       <= pos_next;
      if (accept_wr) flags[wr_state] <= item.accepting;
    end
  end

  always_ff @(posedge clk) begin
    if (trans_wr) tstore[{wr_state, item_sym}] <= item.target_state;
    if (accept_wr) kstore[wr_state] <= item.token_code;
    if (scan_issue) begin
      rdata  <= tstore[{cur_state_next, item_sym}];
      kind_q <= kstore[cur_state_next];
      flag_q <= flags[cur_state_next];
      sym_q  <= item_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= '0;
      ord_ptr <= '0;
      occ     <= '0;
    end else begin
      if (res_push) owr_ptr <= owr_ptr + 1'b1;
      if (drain) ord_ptr <= ord_ptr + 1'b1;
      occ <= occ + dfa_pkg::OCNT_W'(res_push) - dfa_pkg::OCNT_W'(drain);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) obuf[owr_ptr] <= res_new;
  end

  assign res_valid    = (occ != '0);
  assign matched_kind = obuf[ord_ptr].kind;
  assign failed       = obuf[ord_ptr].failed;
  assign word_length  = obuf[ord_ptr].length;

endmodule

/* rtl/core/dfa_token_recognizer_top.sv */
// A scan's result passes the request queue, lookup registers and result buffer.
// Throughput: one request per cycle, loads and scans alike, unless a scan waits
// for a result slot; the loop that sets it is the transition memory read, whose
// registered data addresses the next read. Reset clears queue, scan state (state
// 0, count 0), result buffer and accept flags at once; transition store and token
// kinds are not cleared and must be loaded before use.
module dfa_token_recognizer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [dfa_pkg::REQ_W-1:0]           req_type,
  input  logic [dfa_pkg::IDX_W-1:0]           state_index,
  input  logic [dfa_pkg::CHAR_W-1:0]          symbol,
  input  logic signed [dfa_pkg::TGT_W-1:0]    target_state,
  input  logic                                accepting,
  input  logic [dfa_pkg::KIND_W-1:0]          token_code,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [dfa_pkg::KIND_W-1:0]          matched_kind,
  output logic                                failed,
  output logic [dfa_pkg::LEN_W-1:0]           word_length
);

  logic           item_valid;
  logic           item_pop;
  dfa_pkg::item_t item;

  dfa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .state_index  (state_index),
    .symbol       (symbol),
    .target_state (target_state),
    .accepting    (accepting),
    .token_code   (token_code),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop)
  );

  dfa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .matched_kind (matched_kind),
    .failed       (failed),
    .word_length  (word_length)
  );

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> item_valid)
    else $error("request popped from empty queue");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_match_has_length: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !failed) |-> (word_length != '0))
    else $error("matched word with zero length");

  a_fail_kind_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && failed) |-> (matched_kind == '0))
    else $error("failed word carries a token kind");

endmodule

/* test/dfa_token_recognizer_top_tb.sv */
module dfa_token_recognizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dfa_pkg::*;

  localparam int LIMIT = 20_000;
  localparam int RANDOM_ITEMS = 940;
  // Random words walk only these states and chars; every such entry is loaded first
  localparam int SCAN_STATES = 16;
  localparam int ALPHA_N = 16;

  localparam logic [CHAR_W-1:0] CH_NUL   = 7'd0;
  localparam logic [CHAR_W-1:0] CH_TAB   = 7'd9;
  localparam logic [CHAR_W-1:0] CH_NL    = 7'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
  localparam logic [CHAR_W-1:0] CH_BANG  = 7'h21;
  localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CH_B     = 7'h62;
  localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
  localparam logic [TGT_W-1:0]  NO_EDGE  = 9'h1FF;

  typedef struct {
    item_t it;
    bit    drain;
  } pend_req_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [REQ_W-1:0]   req_type = OP_NONE;
  logic [IDX_W-1:0]   state_index = '0;
  logic [CHAR_W-1:0]  symbol = '0;
  logic signed [TGT_W-1:0] target_state = '0;
  logic               accepting = 1'b0;
  logic [KIND_W-1:0]  token_code = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic [KIND_W-1:0]  matched_kind;
  logic               failed;
  logic [LEN_W-1:0]   word_length;

  dfa_token_recognizer_top u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .state_index  (state_index),
    .symbol       (symbol),
    .target_state (target_state),
    .accepting    (accepting),
    .token_code   (token_code),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .matched_kind (matched_kind),
    .failed       (failed),
    .word_length  (word_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Scanner prediction: tables, walk state and pending word results
  logic [TGT_W-1:0]  trans_model [TABLE_DEPTH];
  bit                accept_flag_model [NUM_STATES];
  logic [KIND_W-1:0] accept_kind_model [NUM_STATES];
  logic [IDX_W-1:0]  scan_state = '0;
  logic [LEN_W-1:0]  scan_len = '0;
  result_t           word_results_q [$];

  // Stimulus planning: shadow of the transition table and of the walk
  logic [TGT_W-1:0]  plan_tab [TABLE_DEPTH];
  logic [IDX_W-1:0]  plan_state = '0;
  pend_req_t         req_q [$];

  int    err_cnt = 0;
  int    cyc = 0;
  bit    req_taken = 1'b0;
  item_t cur_req;
  bit    quiet;

  assign quiet = (cyc >= 400) && (cyc < 800);

  initial begin
    for (int i = 0; i < NUM_STATES; i++) begin
      accept_flag_model[i] = 1'b0;
    end
  end

  function automatic bit is_blank(input logic [CHAR_W-1:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_NUL;
  endfunction

  // Letters a..l, then the four blanks
  function automatic logic [CHAR_W-1:0] alpha_char(input int k);
    logic [CHAR_W-1:0] c;
    case (k)
      12: c = CH_SPACE;
      13: c = CH_TAB;
      14: c = CH_NL;
      15: c = CH_NUL;
      default: c = CHAR_W'(97 + k);
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_char();
    return alpha_char(int'($urandom_range(0, ALPHA_N - 1)));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at cycle %0d: %s", cyc, msg);
    err_cnt++;
  endtask

  task automatic predict_request(input item_t it);
    logic [TGT_W-1:0] nxt;
    result_t          r;
    case (it.op)
      OP_TRANS: begin
        trans_model[{it.state_index, it.symbol}] = it.target_state;
      end
      OP_ACCEPT: begin
        accept_flag_model[it.state_index] = it.accepting;
        accept_kind_model[it.state_index] = it.token_code;
      end
      OP_SCAN: begin
        nxt = trans_model[{scan_state, it.symbol}];
        if (!nxt[TGT_W-1]) begin
          scan_state = nxt[IDX_W-1:0];
          if (scan_len != LEN_MAX) scan_len++;
        end else begin
          // The terminating character counts when nothing came before it
          r.length = (scan_len == '0) ? LEN_W'(1) : scan_len;
          if (scan_len != '0 && accept_flag_model[scan_state] && is_blank(it.symbol)) begin
            r.kind = accept_kind_model[scan_state];
            r.failed = 1'b0;
          end else begin
            r.kind = '0;
            r.failed = 1'b1;
          end
          word_results_q.insert(word_results_q.size(), r);
          scan_state = '0;
          scan_len = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_request(input logic [REQ_W-1:0] op, input logic [IDX_W-1:0] sidx,
                               input logic [CHAR_W-1:0] sym, input logic [TGT_W-1:0] tgt,
                               input logic acc, input logic [KIND_W-1:0] kind,
                               input bit drain = 1'b0);
    pend_req_t        p;
    logic [TGT_W-1:0] t;
    p.it.op = op;
    p.it.state_index = sidx;
    p.it.symbol = sym;
    p.it.target_state = tgt;
    p.it.accepting = acc;
    p.it.token_code = kind;
    p.drain = drain;
    req_q.insert(req_q.size(), p);
    if (op == OP_TRANS) begin
      plan_tab[{sidx, sym}] = tgt;
    end else if (op == OP_SCAN) begin
      t = plan_tab[{plan_state, sym}];
      plan_state = t[TGT_W-1] ? '0 : t[IDX_W-1:0];
    end
  endtask

  task automatic queue_scan(input logic [CHAR_W-1:0] c);
    queue_request(OP_SCAN, IDX_W'($urandom), c, TGT_W'($urandom), 1'($urandom),
                  KIND_W'($urandom));
  endtask

  // Edges only ever lead into the walked states, so no scan reads an unloaded entry
  task automatic queue_noise();
    logic [REQ_W-1:0] op;
    logic [IDX_W-1:0] sidx;
    logic [TGT_W-1:0] tgt;
    op = REQ_W'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 0) sidx = IDX_W'($urandom_range(0, SCAN_STATES - 1));
    else sidx = IDX_W'($urandom);
    if ($urandom_range(0, 1) == 0) tgt = TGT_W'($urandom_range(256, 511));
    else tgt = TGT_W'($urandom_range(0, SCAN_STATES - 1));
    queue_request(op, sidx, rand_char(), tgt, 1'($urandom), KIND_W'($urandom));
  endtask

  // Walk existing edges for a random stretch, then end on a blank or a random character
  task automatic queue_word(inout int cnt);
    int                len;
    bit                found;
    logic [CHAR_W-1:0] c;
    len = int'($urandom_range(1, 10));
    for (int k = 0; k < len; k++) begin
      found = 1'b0;
      for (int tr = 0; tr < 8 && !found; tr++) begin
        c = rand_char();
        if (!plan_tab[{plan_state, c}][TGT_W-1]) found = 1'b1;
      end
      if (!found) break;
      if ($urandom_range(0, 99) < 5) begin
        queue_noise();
        cnt++;
      end
      queue_scan(c);
      cnt++;
    end
    if ($urandom_range(0, 99) < 80) c = alpha_char(int'($urandom_range(12, 15)));
    else c = rand_char();
    queue_scan(c);
    cnt++;
  endtask

  initial begin
    int                cnt;
    bit                drained;
    logic [TGT_W-1:0]  t;
    logic [CHAR_W-1:0] c;

    // Load every walked entry; blanks are loaded with no edge
    for (int s = 0; s < SCAN_STATES; s++) begin
      for (int k = 0; k < ALPHA_N; k++) begin
        c = alpha_char(k);
        if (is_blank(c) || $urandom_range(0, 99) < 35) t = TGT_W'($urandom_range(256, 511));
        else t = TGT_W'($urandom_range(0, SCAN_STATES - 1));
        queue_request(OP_TRANS, IDX_W'(s), c, t, 1'($urandom), KIND_W'($urandom));
      end
    end

    // Directed words
    queue_request(OP_TRANS, 8'd0, CH_A, 9'd1, 1'($urandom), KIND_W'($urandom));
    queue_request(OP_TRANS, 8'd1, CH_B, 9'd2, 1'($urandom), KIND_W'($urandom));
    queue_request(OP_TRANS, 8'd2, CH_X, 9'h100, 1'($urandom), KIND_W'($urandom));
    queue_request(OP_TRANS, 8'd0, CH_BANG, NO_EDGE, 1'($urandom), KIND_W'($urandom));
    // accept flags still clear from reset
    queue_scan(CH_A); queue_scan(CH_B); queue_scan(CH_SPACE);
    queue_request(OP_ACCEPT, 8'd2, rand_char(), TGT_W'($urandom), 1'b1, 8'hFF);
    queue_request(OP_ACCEPT, 8'd1, rand_char(), TGT_W'($urandom), 1'b1, 8'h00);
    queue_scan(CH_A); queue_scan(CH_B); queue_scan(CH_SPACE);
    queue_scan(CH_A); queue_scan(CH_B); queue_scan(CH_TAB);
    queue_scan(CH_A); queue_scan(CH_B); queue_scan(CH_NL);
    queue_scan(CH_A); queue_scan(CH_B); queue_scan(CH_NUL);
    queue_scan(CH_A); queue_scan(CH_B); queue_scan(CH_X);
    queue_scan(CH_BANG);
    queue_scan(CH_SPACE);
    queue_scan(CH_A); queue_scan(CH_TAB);
    queue_request(OP_NONE, IDX_W'($urandom), rand_char(), TGT_W'($urandom), 1'($urandom),
                  KIND_W'($urandom));

    // Accept entries for every walked state; hold until the directed words are out
    for (int s = 0; s < SCAN_STATES; s++) begin
      queue_request(OP_ACCEPT, IDX_W'(s), rand_char(), TGT_W'($urandom), 1'($urandom),
                    KIND_W'($urandom), s == 0);
    end

    cnt = 0;
    drained = 1'b0;
    while (cnt < RANDOM_ITEMS) begin
      if (!drained && cnt >= RANDOM_ITEMS / 2) begin
        queue_request(OP_SCAN, IDX_W'($urandom), CH_SPACE, TGT_W'($urandom), 1'($urandom),
                      KIND_W'($urandom), 1'b1);
        drained = 1'b1;
        cnt++;
      end
      if ($urandom_range(0, 99) < 15) begin
        queue_noise();
        cnt++;
      end else begin
        queue_word(cnt);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_q.size() != 0 || req_valid) @(posedge clk);
    while (word_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Request driver: note acceptance at the rising edge, present at the falling edge
  always @(posedge clk) begin
    req_taken = req_valid && !req_stall;
    if (req_taken) predict_request(cur_req);
  end

  always @(negedge clk) begin
    pend_req_t p;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (req_q.size() != 0 && !(quiet == 1'b0 && $urandom_range(0, 99) < 20) &&
          !(req_q[0].drain && word_results_q.size() != 0)) begin
        p = req_q.pop_front();
        cur_req = p.it;
        req_valid    <= 1'b1;
        req_type     <= cur_req.op;
        state_index  <= cur_req.state_index;
        symbol       <= cur_req.symbol;
        target_state <= cur_req.target_state;
        accepting    <= cur_req.accepting;
        token_code   <= cur_req.token_code;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (word_results_q.size() == 0) begin
        report_mismatch("result arrived with none pending");
      end else begin
        want = word_results_q.pop_front();
        if (matched_kind !== want.kind)
          report_mismatch($sformatf("matched_kind %0d, want %0d", matched_kind, want.kind));
        if (failed !== want.failed)
          report_mismatch($sformatf("failed %0b, want %0b", failed, want.failed));
        if (word_length !== want.length)
          report_mismatch($sformatf("word_length %0d, want %0d", word_length, want.length));
      end
    end
  end

  always @(negedge clk) begin
    res_stall <= !rst && !quiet && ($urandom_range(0, 99) < 20);
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule

/* dfa_token_recognizer_top.f */
rtl/core/dfa_pkg.sv
rtl/core/dfa_front.sv
rtl/core/dfa_back.sv
rtl/core/dfa_token_recognizer_top.sv
test/dfa_token_recognizer_top_tb.sv
